// ===== rtl/dpr_pkg.sv =====
// shared types, widths and codes of the disparity/depth reprojection block
`default_nettype none
package dpr_pkg;

   localparam int COORD_W    = 16;
   localparam int VALUE_W    = 32;
   localparam int COEF_W     = 48;
   localparam int COORD_FRAC = 4;
   localparam int VALUE_FRAC = 16;
   localparam int DIGIT_W    = 16;
   localparam int NUM_DIGITS = (VALUE_W + DIGIT_W - 1) / DIGIT_W;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int NUM_REGS   = 8;
   // four row stages, absolute value, range check, one stage per bit, output
   localparam int PIPE_DEPTH = VALUE_W + 7;
   localparam logic [63:0] COEF_ONE = 64'd16777216;

   localparam logic ACTION_TO_DEPTH = 1'b0;
   localparam logic ACTION_TO_DISP  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_ZERO_DEN,
      STATUS_CLAMP,
      STATUS_SAT
   } status_type;

   typedef enum logic [2:0] {
      REG_DEPTH_X,
      REG_DEPTH_Y,
      REG_DEPTH_D,
      REG_DEPTH_C,
      REG_WEIGHT_X,
      REG_WEIGHT_Y,
      REG_WEIGHT_D,
      REG_WEIGHT_C
   } reg_index_type;

   typedef struct packed {
      logic                      action;
      logic [COORD_W-1:0]        pixel_x;
      logic [COORD_W-1:0]        pixel_y;
      logic signed [VALUE_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value_out;
      status_type                status;
   } rsp_type;

   // stage enables: load for the first stage, shift for the rest
   typedef struct packed {
      logic load;
      logic shift;
   } pipe_ctrl_type;

   // flags that travel beside the divider data
   typedef struct packed {
      logic action;
      logic wzero;
      logic neg;
   } side_type;

   // width of one row's accumulated sum
   function automatic int acc_width(input int coef_bits);
      return coef_bits + COORD_W + 3 + NUM_DIGITS * DIGIT_W + 1;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/dpr_row.sv =====
// one row of the reprojection matrix: four-stage multiply-accumulate pipeline
`default_nettype none
module dpr_row #(
   parameter int COEF_BITS = dpr_pkg::COEF_W
) (
   input  logic                                      clock,
   input  dpr_pkg::pipe_ctrl_type                    ctrl,
   input  logic signed [COEF_BITS-1:0]               coef_x,
   input  logic signed [COEF_BITS-1:0]               coef_y,
   input  logic signed [COEF_BITS-1:0]               coef_d,
   input  logic signed [COEF_BITS-1:0]               coef_c,
   input  logic                                      action,
   input  logic [dpr_pkg::COORD_W-1:0]               pixel_x,
   input  logic [dpr_pkg::COORD_W-1:0]               pixel_y,
   input  logic signed [dpr_pkg::VALUE_W-1:0]        value_in,
   output logic signed [dpr_pkg::acc_width(COEF_BITS)-1:0] row_sum
);

   localparam int PROD_W = COEF_BITS + dpr_pkg::COORD_W + 1;
   localparam int S_W    = PROD_W + 1;
   localparam int A_W    = S_W + 1;
   localparam int B_W    = S_W + dpr_pkg::VALUE_FRAC - dpr_pkg::COORD_FRAC + 1;
   localparam int ND     = dpr_pkg::NUM_DIGITS;
   localparam int DG     = dpr_pkg::DIGIT_W;
   localparam int DE_W   = ND * DG;
   localparam int P_W    = A_W + DG + 1;
   localparam int T_W    = dpr_pkg::acc_width(COEF_BITS);

   logic signed [PROD_W-1:0] px_in, py_in, px_ff, py_ff;
   logic                     act1_ff;
   logic signed [dpr_pkg::VALUE_W-1:0] d1_ff;
   logic signed [S_W-1:0]    s_sum;
   logic signed [A_W-1:0]    a_in, a_ff;
   logic signed [B_W-1:0]    b_in, b_ff, b3_ff;
   logic signed [DE_W-1:0]   d2_ff;
   logic signed [P_W-1:0]    p_in [ND];
   logic signed [P_W-1:0]    p_ff [ND];
   logic signed [T_W-1:0]    t_in, t_ff;

   // stage 1: coordinate products
   always_comb begin
      px_in = PROD_W'(coef_x) * PROD_W'($signed({1'b0, pixel_x}));
      py_in = PROD_W'(coef_y) * PROD_W'($signed({1'b0, pixel_y}));
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         act1_ff <= action;
         d1_ff   <= value_in;
      end
   end

   // stage 2: multiplicand for the value and the additive term
   always_comb begin
      s_sum = S_W'(px_ff) + S_W'(py_ff);
      if (act1_ff == dpr_pkg::ACTION_TO_DISP) begin
         a_in = A_W'(s_sum) + (A_W'(coef_d) <<< dpr_pkg::COORD_FRAC);
         b_in = B_W'(coef_c) <<< (dpr_pkg::VALUE_FRAC + dpr_pkg::COORD_FRAC);
      end else begin
         a_in = -A_W'(coef_d);
         b_in = (B_W'(s_sum) <<< (dpr_pkg::VALUE_FRAC - dpr_pkg::COORD_FRAC))
              + (B_W'(coef_c) <<< dpr_pkg::VALUE_FRAC);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         d2_ff   <= DE_W'(d1_ff);
      end
   end

   // stage 3: one partial product per value digit, top digit signed
   always_comb begin
      logic signed [DG:0] dig_s;
      for (int k = 0; k < ND; k++) begin
         if (k == ND - 1) dig_s = $signed({d2_ff[DE_W-1], d2_ff[k*DG +: DG]});
         else             dig_s = $signed({1'b0, d2_ff[k*DG +: DG]});
         p_in[k] = P_W'(a_ff) * P_W'(dig_s);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         for (int k = 0; k < ND; k++) p_ff[k] <= p_in[k];
         b3_ff <= b_ff;
      end
   end

   // stage 4: align and sum the partial products
   always_comb begin
      t_in = T_W'(b3_ff);
      for (int k = 0; k < ND; k++) t_in = t_in + (T_W'(p_ff[k]) <<< (k * DG));
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) t_ff <= t_in;
   end

   assign row_sum = t_ff;

endmodule
`default_nettype wire

// ===== rtl/dpr_div.sv =====
// pipelined signed divider with saturation and result status, one bit per stage
`default_nettype none
module dpr_div #(
   parameter int COEF_BITS = dpr_pkg::COEF_W
) (
   input  logic                                           clock,
   input  logic                                           shift,
   input  logic                                           action,
   input  logic signed [dpr_pkg::acc_width(COEF_BITS)-1:0] depth_sum,
   input  logic signed [dpr_pkg::acc_width(COEF_BITS)-1:0] weight_sum,
   output dpr_pkg::rsp_type                               result
);

   localparam int T_W = dpr_pkg::acc_width(COEF_BITS);
   localparam int V   = dpr_pkg::VALUE_W;
   localparam int R_W = T_W + V;
   localparam logic [V-1:0] LIM = {1'b1, {(V-1){1'b0}}};

   logic [T_W-1:0]     n_in, n_ff, dm_in, dm_ff;
   dpr_pkg::side_type  sa_in, sa_ff;
   logic               zneg, zpos, numneg;
   logic [R_W-1:0]     num_w, den_w;

   logic [R_W-1:0]     rem_ff  [V+1];
   logic [T_W-1:0]     den_ff  [V+1];
   logic [V-1:0]       q_ff    [V+1];
   dpr_pkg::side_type  side_ff [V+1];
   logic               big_ff  [V+1];

   logic [V-1:0]       q;
   logic               big, qzero, negf;
   dpr_pkg::rsp_type   rsp_in, rsp_ff;

   // magnitudes and sign of the quotient
   always_comb begin
      zneg     = depth_sum[T_W-1];
      zpos     = !zneg && (depth_sum != '0);
      numneg   = (action == dpr_pkg::ACTION_TO_DISP) ? zpos : zneg;
      n_in     = zneg ? T_W'(-depth_sum) : T_W'(depth_sum);
      dm_in    = weight_sum[T_W-1] ? T_W'(-weight_sum) : T_W'(weight_sum);
      sa_in.action = action;
      sa_in.wzero  = (weight_sum == '0);
      sa_in.neg    = numneg ^ weight_sum[T_W-1];
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         n_ff  <= n_in;
         dm_ff <= dm_in;
         sa_ff <= sa_in;
      end
   end

   // range check: quotient must fit below 2^V
   always_comb begin
      num_w = R_W'({n_ff, {dpr_pkg::VALUE_FRAC{1'b0}}});
      den_w = {dm_ff, {V{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         rem_ff[0]  <= num_w;
         den_ff[0]  <= dm_ff;
         q_ff[0]    <= '0;
         side_ff[0] <= sa_ff;
         big_ff[0]  <= (num_w >= den_w);
      end
   end

   // restoring steps, most significant quotient bit first
   for (genvar k = 0; k < V; k++) begin : g_step
      logic [R_W:0] trial;
      assign trial = {1'b0, rem_ff[k]} - {1'b0, R_W'(den_ff[k]) << (V - 1 - k)};
      always_ff @(posedge clock) begin
         if (shift) begin
            rem_ff[k+1]  <= trial[R_W] ? rem_ff[k] : trial[R_W-1:0];
            q_ff[k+1]    <= {q_ff[k][V-2:0], !trial[R_W]};
            den_ff[k+1]  <= den_ff[k];
            side_ff[k+1] <= side_ff[k];
            big_ff[k+1]  <= big_ff[k];
         end
      end
   end

   // status and saturation
   always_comb begin
      q     = q_ff[V];
      big   = big_ff[V] || (side_ff[V].neg ? (q > LIM) : (q >= LIM));
      qzero = !big_ff[V] && (q == '0);
      negf  = side_ff[V].neg && !qzero;
      rsp_in.value_out = '0;
      rsp_in.status    = dpr_pkg::STATUS_OK;
      if (side_ff[V].wzero) begin
         rsp_in.status = dpr_pkg::STATUS_ZERO_DEN;
      end else if (side_ff[V].action == dpr_pkg::ACTION_TO_DEPTH && (negf || qzero)) begin
         rsp_in.status = dpr_pkg::STATUS_CLAMP;
      end else if (big) begin
         rsp_in.status    = dpr_pkg::STATUS_SAT;
         rsp_in.value_out = negf ? $signed(LIM) : $signed(~LIM);
      end else begin
         rsp_in.value_out = negf ? $signed(-q) : $signed(q);
      end
   end

   always_ff @(posedge clock) begin
      if (shift) rsp_ff <= rsp_in;
   end

   assign result = rsp_ff;

endmodule
`default_nettype wire

// ===== rtl/disparity_depth_reprojection.sv =====
// top level: configuration registers, pipeline control, depth and weight rows, divider
`default_nettype none
// Converts a rectified pixel's disparity to depth (action 0) or depth to disparity
// (action 1) using the depth and weight rows of a stereo reprojection matrix, eight
// signed Q24.24 registers at byte addresses 0x00..0x38 (8 apart) of the APB port.
// Fully pipelined: one pixel is taken every clock while the output is not held; the
// divider resolves one quotient bit per stage. A rsp_stall held while a result waits
// freezes the pipeline; an empty first stage still takes a transfer. Status: 0 ok,
// 1 zero denominator, 2 non-positive depth, 3 saturated.
module disparity_depth_reprojection #(
   parameter int COEF_BITS = dpr_pkg::COEF_W
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  dpr_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output dpr_pkg::rsp_type                  rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dpr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [dpr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [dpr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int L   = dpr_pkg::PIPE_DEPTH;
   localparam int T_W = dpr_pkg::acc_width(COEF_BITS);

   logic signed [COEF_BITS-1:0] coef_ff [dpr_pkg::NUM_REGS];
   logic [2:0]                  reg_idx;
   logic                        csr_wr;
   logic [L-1:0]                v_ff, v_in;
   logic                        en;
   dpr_pkg::pipe_ctrl_type      ctrl;
   logic                        act_ff [4];
   logic signed [T_W-1:0]       depth_sum, weight_sum;

   // register file
   assign reg_idx    = csr_paddr[5:3];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = dpr_pkg::CSR_DATA_W'(coef_ff[reg_idx]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dpr_pkg::NUM_REGS; i++) begin
            if (i == int'(dpr_pkg::REG_DEPTH_C) || i == int'(dpr_pkg::REG_WEIGHT_C))
               coef_ff[i] <= COEF_BITS'(dpr_pkg::COEF_ONE);
            else
               coef_ff[i] <= '0;
         end
      end else if (csr_wr) begin
         coef_ff[reg_idx] <= csr_pwdata[COEF_BITS-1:0];
      end
   end

   // pipeline control: whole pipe moves unless the output transfer is held
   assign en         = !(v_ff[L-1] && rsp_stall);
   assign ctrl.shift = en;
   assign ctrl.load  = en || !v_ff[0];
   assign req_stall  = !ctrl.load;
   assign rsp_valid  = v_ff[L-1];

   always_comb begin
      v_in = v_ff;
      if (en)             v_in = {v_ff[L-2:0], req_valid};
      else if (!v_ff[0])  v_in[0] = req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else       v_ff <= v_in;
   end

   // action rides beside the row stages
   always_ff @(posedge clock) begin
      if (ctrl.load) act_ff[0] <= req_data.action;
      if (ctrl.shift) begin
         for (int i = 1; i < 4; i++) act_ff[i] <= act_ff[i-1];
      end
   end

   dpr_row #(.COEF_BITS(COEF_BITS)) u_depth_row (
      .clock    (clock),
      .ctrl     (ctrl),
      .coef_x   (coef_ff[dpr_pkg::REG_DEPTH_X]),
      .coef_y   (coef_ff[dpr_pkg::REG_DEPTH_Y]),
      .coef_d   (coef_ff[dpr_pkg::REG_DEPTH_D]),
      .coef_c   (coef_ff[dpr_pkg::REG_DEPTH_C]),
      .action   (req_data.action),
      .pixel_x  (req_data.pixel_x),
      .pixel_y  (req_data.pixel_y),
      .value_in (req_data.value_in),
      .row_sum  (depth_sum)
   );

   dpr_row #(.COEF_BITS(COEF_BITS)) u_weight_row (
      .clock    (clock),
      .ctrl     (ctrl),
      .coef_x   (coef_ff[dpr_pkg::REG_WEIGHT_X]),
      .coef_y   (coef_ff[dpr_pkg::REG_WEIGHT_Y]),
      .coef_d   (coef_ff[dpr_pkg::REG_WEIGHT_D]),
      .coef_c   (coef_ff[dpr_pkg::REG_WEIGHT_C]),
      .action   (req_data.action),
      .pixel_x  (req_data.pixel_x),
      .pixel_y  (req_data.pixel_y),
      .value_in (req_data.value_in),
      .row_sum  (weight_sum)
   );

   dpr_div #(.COEF_BITS(COEF_BITS)) u_div (
      .clock      (clock),
      .shift      (ctrl.shift),
      .action     (act_ff[3]),
      .depth_sum  (depth_sum),
      .weight_sum (weight_sum),
      .result     (rsp_data)
   );

   // checks
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v_ff[0] && v_ff[L-1] && rsp_stall))
      else $error("input held while first stage free");

   a_valid_advances: assert property (@(posedge clock) disable iff (reset)
      en |=> (v_ff[1] == $past(v_ff[0])))
      else $error("valid bit lost or duplicated in pipeline");

   a_flagged_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == dpr_pkg::STATUS_ZERO_DEN ||
                     rsp_data.status == dpr_pkg::STATUS_CLAMP))
      |-> (rsp_data.value_out == '0))
      else $error("flagged result carries a value");

   a_sat_is_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == dpr_pkg::STATUS_SAT)
      |-> (rsp_data.value_out[dpr_pkg::VALUE_W-2:0] == '0 ||
           rsp_data.value_out[dpr_pkg::VALUE_W-2:0] == '1))
      else $error("saturated result is not a range bound");

endmodule
`default_nettype wire

// ===== test/tb_disparity_depth_reprojection.sv =====
// testbench of the disparity/depth reprojection block: directed table, then random pixels
`timescale 1ns / 1ps
module tb_disparity_depth_reprojection;

   typedef enum logic {ROW_ITEM, ROW_REG} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      dpr_pkg::req_type       pixel;
      dpr_pkg::reg_index_type idx;
      logic [63:0]            wval;
      logic                   typed;
      dpr_pkg::rsp_type       want;
   } row_type;

   localparam logic [63:0] COEF_MAX     = 64'h0000_7FFF_FFFF_FFFF;
   localparam logic [63:0] COEF_MIN     = 64'hFFFF_8000_0000_0000;
   localparam logic [63:0] COEF_NEG_ONE = 64'hFFFF_FFFF_FF00_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   dpr_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   dpr_pkg::rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [dpr_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [dpr_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [dpr_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // shadow of the coefficient registers
   logic signed [dpr_pkg::COEF_W-1:0] coef_q [dpr_pkg::NUM_REGS];
   dpr_pkg::rsp_type pending_q [$];
   int errors = 0;
   int send_idle = 0;
   int recv_idle = 0;
   row_type rows [$];

   disparity_depth_reprojection u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_disparity_depth_reprojection NOT OK");
      $finish;
   end

   // exact wide-integer reprojection of one pixel
   function automatic dpr_pkg::rsp_type reproject(dpr_pkg::req_type p);
      logic signed [255:0] c [dpr_pkg::NUM_REGS];
      logic signed [255:0] x, y, d, wt, zt, num;
      logic [255:0] nmag, dmag, quo;
      logic neg, big;
      dpr_pkg::rsp_type res;
      for (int i = 0; i < dpr_pkg::NUM_REGS; i++) c[i] = coef_q[i];
      x = $signed({240'b0, p.pixel_x});
      y = $signed({240'b0, p.pixel_y});
      d = p.value_in;
      if (p.action == dpr_pkg::ACTION_TO_DEPTH) begin
         wt = ((c[dpr_pkg::REG_WEIGHT_X] * x + c[dpr_pkg::REG_WEIGHT_Y] * y)
               <<< (dpr_pkg::VALUE_FRAC - dpr_pkg::COORD_FRAC))
              - c[dpr_pkg::REG_WEIGHT_D] * d
              + (c[dpr_pkg::REG_WEIGHT_C] <<< dpr_pkg::VALUE_FRAC);
         zt = ((c[dpr_pkg::REG_DEPTH_X] * x + c[dpr_pkg::REG_DEPTH_Y] * y)
               <<< (dpr_pkg::VALUE_FRAC - dpr_pkg::COORD_FRAC))
              - c[dpr_pkg::REG_DEPTH_D] * d
              + (c[dpr_pkg::REG_DEPTH_C] <<< dpr_pkg::VALUE_FRAC);
         num = zt <<< dpr_pkg::VALUE_FRAC;
      end else begin
         wt = (c[dpr_pkg::REG_WEIGHT_X] * x + c[dpr_pkg::REG_WEIGHT_Y] * y
               + (c[dpr_pkg::REG_WEIGHT_D] <<< dpr_pkg::COORD_FRAC)) * d
              + (c[dpr_pkg::REG_WEIGHT_C] <<< (dpr_pkg::COORD_FRAC + dpr_pkg::VALUE_FRAC));
         zt = (c[dpr_pkg::REG_DEPTH_X] * x + c[dpr_pkg::REG_DEPTH_Y] * y
               + (c[dpr_pkg::REG_DEPTH_D] <<< dpr_pkg::COORD_FRAC)) * d
              + (c[dpr_pkg::REG_DEPTH_C] <<< (dpr_pkg::COORD_FRAC + dpr_pkg::VALUE_FRAC));
         num = -(zt <<< dpr_pkg::VALUE_FRAC);
      end
      res.value_out = '0;
      res.status = dpr_pkg::STATUS_OK;
      if (wt == 0) begin
         res.status = dpr_pkg::STATUS_ZERO_DEN;
      end else begin
         neg = num[255] != wt[255];
         nmag = num[255] ? -num : num;
         dmag = wt[255] ? -wt : wt;
         quo = nmag / dmag;
         if (quo == 0) neg = 1'b0;
         big = neg ? (quo > 256'h8000_0000) : (quo > 256'h7FFF_FFFF);
         if (p.action == dpr_pkg::ACTION_TO_DEPTH && (neg || quo == 0)) begin
            res.status = dpr_pkg::STATUS_CLAMP;
         end else if (big) begin
            res.status = dpr_pkg::STATUS_SAT;
            res.value_out = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end else begin
            res.value_out = neg ? -quo[31:0] : quo[31:0];
         end
      end
      return res;
   endfunction

   function automatic row_type pix_row(logic a, logic [15:0] x, logic [15:0] y,
                                       logic [31:0] v, logic typed, logic [31:0] wv,
                                       dpr_pkg::status_type ws);
      row_type r;
      r.kind = ROW_ITEM;
      r.pixel = '{action: a, pixel_x: x, pixel_y: y, value_in: v};
      r.idx = dpr_pkg::REG_DEPTH_X;
      r.wval = '0;
      r.typed = typed;
      r.want = '{value_out: wv, status: ws};
      return r;
   endfunction

   function automatic row_type reg_row(dpr_pkg::reg_index_type idx, logic [63:0] v);
      row_type r;
      r = pix_row(1'b0, '0, '0, '0, 1'b0, '0, dpr_pkg::STATUS_OK);
      r.kind = ROW_REG;
      r.idx = idx;
      r.wval = v;
      return r;
   endfunction

   function automatic logic [63:0] rand_coef();
      logic [63:0] v;
      case ($urandom_range(7))
         0: v = '0;
         1: v = COEF_MAX;
         2: v = COEF_MIN;
         3: v = dpr_pkg::COEF_ONE;
         4: v = COEF_NEG_ONE;
         5, 6: v = 64'($signed(32'($urandom_range(32'h1FFF_FFFF)) - 32'h1000_0000));
         default: v = {$urandom(), $urandom()} & 64'h0000_FFFF_FFFF_FFFF;
      endcase
      // upper bits as a sign extension of bit 47
      return {{16{v[47]}}, v[47:0]};
   endfunction

   function automatic dpr_pkg::req_type rand_pixel();
      dpr_pkg::req_type p;
      p.action = 1'($urandom_range(1));
      p.pixel_x = 16'($urandom());
      p.pixel_y = 16'($urandom());
      case ($urandom_range(5))
         0, 1: p.value_in = $urandom();
         2, 3: p.value_in = $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
         4: p.value_in = '0;
         default: p.value_in = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
      return p;
   endfunction

   // one register write in setup and access cycles
   task automatic write_coef(dpr_pkg::reg_index_type idx, logic [63:0] v);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= dpr_pkg::CSR_ADDR_W'(idx) << 3;
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      coef_q[idx] = v[dpr_pkg::COEF_W-1:0];
   endtask

   // hold the sender until the pipeline has emptied
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (dpr_pkg::PIPE_DEPTH + 4) @(posedge clock);
   endtask

   // present one pixel and wait for its transfer
   task automatic send_pixel(dpr_pkg::req_type p, logic typed, dpr_pkg::rsp_type want);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_q.push_back(typed ? want : reproject(p));
   endtask

   // result side: check transfers, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_q.size() == 0) begin
               $display("%0t unexpected result %h", $time, rsp_data);
               errors++;
            end else begin
               if (rsp_data.value_out !== pending_q[0].value_out) begin
                  $display("%0t value_out expected %h actual %h", $time,
                           pending_q[0].value_out, rsp_data.value_out);
                  errors++;
               end
               if (rsp_data.status !== pending_q[0].status) begin
                  $display("%0t status expected %0d actual %0d", $time,
                           pending_q[0].status, rsp_data.status);
                  errors++;
               end
               void'(pending_q.pop_front());
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   initial begin
      dpr_pkg::rsp_type none;
      none = '0;
      for (int i = 0; i < dpr_pkg::NUM_REGS; i++) coef_q[i] = '0;
      coef_q[dpr_pkg::REG_DEPTH_C] = dpr_pkg::COEF_ONE[dpr_pkg::COEF_W-1:0];
      coef_q[dpr_pkg::REG_WEIGHT_C] = dpr_pkg::COEF_ONE[dpr_pkg::COEF_W-1:0];

      // after reset the unit maps depth to 1.0 and disparity to -1.0
      rows.push_back(pix_row(1'b0, 16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 32'h0001_0000,
                             dpr_pkg::STATUS_OK));
      rows.push_back(pix_row(1'b0, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 1'b1, 32'h0001_0000,
                             dpr_pkg::STATUS_OK));
      rows.push_back(pix_row(1'b0, 16'h0000, 16'hFFFF, 32'h8000_0000, 1'b1, 32'h0001_0000,
                             dpr_pkg::STATUS_OK));
      rows.push_back(pix_row(1'b1, 16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 32'hFFFF_0000,
                             dpr_pkg::STATUS_OK));
      rows.push_back(pix_row(1'b1, 16'hFFFF, 16'hFFFF, 32'h8000_0000, 1'b1, 32'hFFFF_0000,
                             dpr_pkg::STATUS_OK));
      rows.push_back(pix_row(1'b1, 16'hFFFF, 16'h0000, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_0000,
                             dpr_pkg::STATUS_OK));
      // zero denominator
      rows.push_back(reg_row(dpr_pkg::REG_WEIGHT_C, '0));
      rows.push_back(pix_row(1'b0, 16'h1234, 16'h5678, 32'h0001_0000, 1'b1, '0,
                             dpr_pkg::STATUS_ZERO_DEN));
      rows.push_back(pix_row(1'b1, 16'hABCD, 16'h0F0F, 32'hFFF0_0000, 1'b1, '0,
                             dpr_pkg::STATUS_ZERO_DEN));
      // negative depth is clamped, disparity keeps its sign
      rows.push_back(reg_row(dpr_pkg::REG_WEIGHT_C, dpr_pkg::COEF_ONE));
      rows.push_back(reg_row(dpr_pkg::REG_DEPTH_C, COEF_NEG_ONE));
      rows.push_back(pix_row(1'b0, 16'h0100, 16'h0200, 32'h0004_0000, 1'b1, '0,
                             dpr_pkg::STATUS_CLAMP));
      rows.push_back(pix_row(1'b1, 16'h0100, 16'h0200, 32'h0004_0000, 1'b1, 32'h0001_0000,
                             dpr_pkg::STATUS_OK));
      // huge numerator over a tiny weight saturates both ways
      rows.push_back(reg_row(dpr_pkg::REG_DEPTH_C, COEF_MAX));
      rows.push_back(reg_row(dpr_pkg::REG_WEIGHT_C, 64'd1));
      rows.push_back(pix_row(1'b0, 16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF,
                             dpr_pkg::STATUS_SAT));
      rows.push_back(pix_row(1'b1, 16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 32'h8000_0000,
                             dpr_pkg::STATUS_SAT));
      // a stereo-like matrix, checked by the predictor
      rows.push_back(reg_row(dpr_pkg::REG_WEIGHT_X, '0));
      rows.push_back(reg_row(dpr_pkg::REG_WEIGHT_Y, COEF_MIN));
      rows.push_back(reg_row(dpr_pkg::REG_WEIGHT_D, 64'd16777216 / 10));
      rows.push_back(reg_row(dpr_pkg::REG_WEIGHT_C, dpr_pkg::COEF_ONE));
      rows.push_back(reg_row(dpr_pkg::REG_DEPTH_X, 64'hFFFF_FFFF_FFF0_0000));
      rows.push_back(reg_row(dpr_pkg::REG_DEPTH_Y, dpr_pkg::COEF_ONE));
      rows.push_back(reg_row(dpr_pkg::REG_DEPTH_D, COEF_MAX));
      rows.push_back(reg_row(dpr_pkg::REG_DEPTH_C, 64'd700 << 24));
      rows.push_back(pix_row(1'b0, 16'h1400, 16'h0F00, 32'h0020_0000, 1'b0, '0,
                             dpr_pkg::STATUS_OK));
      rows.push_back(pix_row(1'b0, 16'hFFFF, 16'h0000, 32'h8000_0000, 1'b0, '0,
                             dpr_pkg::STATUS_OK));
      rows.push_back(pix_row(1'b1, 16'h1400, 16'h0F00, 32'h0100_0000, 1'b0, '0,
                             dpr_pkg::STATUS_OK));
      rows.push_back(pix_row(1'b1, 16'h0000, 16'hFFFF, 32'h7FFF_FFFF, 1'b0, '0,
                             dpr_pkg::STATUS_OK));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (rows[i]) begin
         if (rows[i].kind == ROW_REG) begin
            drain();
            write_coef(rows[i].idx, rows[i].wval);
         end else begin
            send_pixel(rows[i].pixel, rows[i].typed, rows[i].want);
         end
      end

      // random phases: both sides idle, the receiver more, then the sender more, then neither
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 31 : (ph == 1) ? 54 : 0;
         recv_idle = (ph == 0) ? 54 : (ph == 1) ? 31 : 0;
         for (int n = 0; n < 270; n++) begin
            if (n % 90 == 0) begin
               drain();
               for (int r = 0; r < dpr_pkg::NUM_REGS; r++)
                  write_coef(dpr_pkg::reg_index_type'(r), rand_coef());
            end
            send_pixel(rand_pixel(), 1'b0, none);
         end
      end

      drain();
      if (errors == 0) begin
         $display("tb_disparity_depth_reprojection OK");
      end else begin
         $display("tb_disparity_depth_reprojection NOT OK");
      end
      $finish;
   end

endmodule

// ===== disparity_depth_reprojection.f =====
rtl/dpr_pkg.sv
rtl/dpr_row.sv
rtl/dpr_div.sv
rtl/disparity_depth_reprojection.sv
test/tb_disparity_depth_reprojection.sv
